[hdl/rmd_pkg.sv]
// running median / distance package: sizes, address widths, types
// no dependencies
`default_nettype none
package rmd_pkg;
  localparam int MaxPoints  = 4096;
  localparam int CoordBits  = 32;
  localparam int HeapDepth  = (MaxPoints + 1) / 2;
  localparam int AddrBits   = $clog2(HeapDepth);
  localparam int CountBits  = $clog2(MaxPoints + 1);
  localparam int TotalBits  = 48;
  localparam logic [TotalBits-1:0] TotalMax = {TotalBits{1'b1}};

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [AddrBits:0] hidx_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [TotalBits-1:0] total_t;
endpackage
`default_nettype wire

[hdl/rmd_if.sv]
// valid/ready channel interfaces for the running median block
// depends on rmd_pkg
`default_nettype none
interface rmd_in_if;
  logic valid;
  logic ready;
  logic new_case;
  rmd_pkg::coord_t x_coord;
  rmd_pkg::coord_t y_coord;
  modport source (output valid, new_case, x_coord, y_coord, input ready);
  modport sink (input valid, new_case, x_coord, y_coord, output ready);
endinterface

interface rmd_out_if;
  logic valid;
  logic ready;
  rmd_pkg::coord_t median_x;
  rmd_pkg::coord_t median_y;
  rmd_pkg::total_t total_distance;
  logic dropped;
  modport source (output valid, median_x, median_y, total_distance, dropped, input ready);
  modport sink (input valid, median_x, median_y, total_distance, dropped, output ready);
endinterface
`default_nettype wire

[hdl/running_median_2d_distance_top.sv]
// running 2-D median and distance total, top level
// depends on rmd_pkg and rmd_if; holds one heap memory for all four heaps
//
// usage: one point beat on in_ (new_case, x_coord, y_coord) gives one result
// beat on out_ (median_x, median_y, total_distance, dropped).
// the x then the y coordinate is inserted by a sequencer over one memory
// with a registered read: a pushpop sift-down on one heap (per level: read
// two children, then compare and write) and a push sift-up on the other
// (per level: read the parent, then compare and write), then the lower tops
// are read back when the count turns odd. one point is in flight at a time:
// in_ready is low from acceptance until its result is loaded, so the next
// point can be accepted in the same cycle as the previous result appears.
// the result sits in an output register; a stalled receiver holds it and
// the next point is then taken and processed, but it waits before loading
// until the held result is taken, and no further point is accepted meanwhile.
// reset clears the count, medians, total and channel state; the memory needs
// no clearing since an entry is read only below the heap size.
// new_case empties the set without touching the memory.
`default_nettype none
module running_median_2d_distance_top (
  input  wire logic clk,
  input  wire logic rst_n,
  rmd_in_if.sink    in_ch,
  rmd_out_if.source out_ch
);
  localparam int AB = rmd_pkg::AddrBits;
  localparam int CB = rmd_pkg::CoordBits;
  localparam int MemDepth = 4 * rmd_pkg::HeapDepth;

  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_PP0 = 4'd2, S_PPTOP = 4'd3,
                         S_PPC = 4'd4, S_PPR1 = 4'd5, S_PPR2 = 4'd6, S_PU0 = 4'd7,
                         S_PUR = 4'd8, S_PUC = 4'd9, S_NEXT = 4'd10, S_MRX = 4'd11,
                         S_MRY = 4'd12, S_DIST = 4'd13, S_OUT = 4'd14;

  // heap select: {axis, upper}
  localparam logic [1:0] H_XLO = 2'b00, H_YLO = 2'b10;

  // heap store, address {axis, upper, index}
  rmd_pkg::coord_t heap_mem [MemDepth];
  rmd_pkg::coord_t rdata_r;
  logic            mem_re, mem_we;
  logic [AB+1:0]   mem_raddr, mem_waddr;
  rmd_pkg::coord_t mem_wdata;

  logic [3:0]      state_r;
  logic            axis_r;        // 0 x, 1 y
  rmd_pkg::count_t count_r;
  rmd_pkg::coord_t med_x_r, med_y_r, px_r, py_r, val_r, top_r, c1_r;
  rmd_pkg::hidx_t  i_r, c_r;
  rmd_pkg::total_t total_r;
  logic            pend_r, pnew_r, drop_r;
  logic            ov_r;
  rmd_pkg::coord_t o_mx_r, o_my_r;
  rmd_pkg::total_t o_tot_r;
  logic            o_drop_r;

  function automatic logic ahead(input logic is_max, input rmd_pkg::coord_t a,
                                 input rmd_pkg::coord_t b);
    return is_max ? (a > b) : (a < b);
  endfunction

  // even count: pushpop upper, push lower; odd count: the other way round
  logic       p_max, u_max;
  logic [1:0] p_sel, u_sel;
  assign p_max = count_r[0];
  assign u_max = ~count_r[0];
  assign p_sel = {axis_r, ~count_r[0]};
  assign u_sel = {axis_r, count_r[0]};

  rmd_pkg::hidx_t n_p, n_u;
  assign n_u = count_r[rmd_pkg::CountBits-1:1];
  assign n_p = n_u + rmd_pkg::hidx_t'(count_r[0]);

  rmd_pkg::hidx_t c_first, c_second, c_par;
  assign c_first  = {i_r[AB-1:0], 1'b1};
  assign c_second = c_r + rmd_pkg::hidx_t'(1);
  assign c_par    = (i_r - rmd_pkg::hidx_t'(1)) >> 1;

  // sift-down child choice and the sift-up compare
  logic            has_two, sd_take2, sd_go, pu_go;
  rmd_pkg::coord_t sd_best;
  rmd_pkg::hidx_t  sd_bidx;
  assign has_two  = c_second < n_p;
  assign sd_take2 = (state_r == S_PPR2) && ahead(p_max, rdata_r, c1_r);
  assign sd_best  = (state_r == S_PPR2 && !sd_take2) ? c1_r : rdata_r;
  assign sd_bidx  = sd_take2 ? c_second : c_r;
  assign sd_go    = ahead(p_max, sd_best, val_r);
  assign pu_go    = ahead(u_max, val_r, rdata_r);

  logic full;
  assign full = count_r >= rmd_pkg::count_t'(rmd_pkg::MaxPoints);

  // distance terms
  logic signed [CB:0] dx_s, dy_s;
  logic [CB:0] dx, dy;
  logic [CB+1:0] dsum;
  logic [rmd_pkg::TotalBits:0] tsum;
  rmd_pkg::total_t total_nxt;
  always_comb begin
    dx_s = {med_x_r[CB-1], med_x_r} - {px_r[CB-1], px_r};
    dy_s = {med_y_r[CB-1], med_y_r} - {py_r[CB-1], py_r};
    dx = dx_s[CB] ? $unsigned(-dx_s) : $unsigned(dx_s);
    dy = dy_s[CB] ? $unsigned(-dy_s) : $unsigned(dy_s);
    dsum = {1'b0, dx} + {1'b0, dy};
    tsum = {1'b0, total_r} + (rmd_pkg::TotalBits+1)'(dsum);
    total_nxt = tsum[rmd_pkg::TotalBits] ? rmd_pkg::TotalMax
                                         : tsum[rmd_pkg::TotalBits-1:0];
  end

  logic take, out_load;
  assign in_ch.ready = !pend_r;
  assign take = in_ch.valid && !pend_r;
  assign out_load = (state_r == S_OUT) && (!ov_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (mem_we) heap_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= heap_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pend_r <= 1'b0; axis_r <= 1'b0; drop_r <= 1'b0;
      count_r <= '0; med_x_r <= '0; med_y_r <= '0; total_r <= '0;
    end else begin
      if (take) begin
        pend_r <= 1'b1; pnew_r <= in_ch.new_case;
        px_r <= in_ch.x_coord; py_r <= in_ch.y_coord;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (pend_r) begin
          if (pnew_r) begin
            count_r <= '0; med_x_r <= '0; med_y_r <= '0; total_r <= '0;
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          axis_r <= 1'b0; val_r <= px_r; drop_r <= full;
          state_r <= full ? S_OUT : S_PP0;
        end
        S_PP0: state_r <= (n_p == '0) ? S_PU0 : S_PPTOP;
        S_PPTOP: if (ahead(p_max, rdata_r, val_r)) begin
          top_r <= rdata_r; i_r <= '0; state_r <= S_PPC;
        end else begin
          state_r <= S_PU0;
        end
        S_PPC: begin
          c_r <= c_first;
          if (c_first >= n_p) begin
            val_r <= top_r; state_r <= S_PU0;
          end else begin
            state_r <= S_PPR1;
          end
        end
        S_PPR1: begin
          c1_r <= rdata_r;
          if (has_two) state_r <= S_PPR2;
          else if (sd_go) begin
            i_r <= sd_bidx; state_r <= S_PPC;
          end else begin
            val_r <= top_r; state_r <= S_PU0;
          end
        end
        S_PPR2: if (sd_go) begin
          i_r <= sd_bidx; state_r <= S_PPC;
        end else begin
          val_r <= top_r; state_r <= S_PU0;
        end
        S_PU0: begin
          i_r <= n_u; state_r <= S_PUR;
        end
        S_PUR: state_r <= (i_r == '0) ? S_NEXT : S_PUC;
        S_PUC: if (pu_go) begin
          i_r <= c_par; state_r <= S_PUR;
        end else begin
          state_r <= S_NEXT;
        end
        S_NEXT: if (!axis_r) begin
          axis_r <= 1'b1; val_r <= py_r; state_r <= S_PP0;
        end else begin
          count_r <= count_r + rmd_pkg::count_t'(1);
          // count turns odd: fetch the new lower tops
          state_r <= count_r[0] ? S_DIST : S_MRX;
        end
        S_MRX: begin
          med_x_r <= rdata_r; state_r <= S_MRY;
        end
        S_MRY: begin
          med_y_r <= rdata_r; state_r <= S_DIST;
        end
        S_DIST: begin
          total_r <= total_nxt; state_r <= S_OUT;
        end
        S_OUT: if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // memory port control
  always_comb begin
    mem_re = 1'b0; mem_we = 1'b0;
    mem_raddr = '0; mem_waddr = '0; mem_wdata = val_r;
    unique case (state_r)
      S_PP0: begin
        mem_re = n_p != '0; mem_raddr = {p_sel, {AB{1'b0}}};
      end
      S_PPC: if (c_first >= n_p) begin
        mem_we = 1'b1; mem_waddr = {p_sel, i_r[AB-1:0]};
      end else begin
        mem_re = 1'b1; mem_raddr = {p_sel, c_first[AB-1:0]};
      end
      S_PPR1: if (has_two) begin
        mem_re = 1'b1; mem_raddr = {p_sel, c_second[AB-1:0]};
      end else begin
        mem_we = 1'b1; mem_waddr = {p_sel, i_r[AB-1:0]};
        mem_wdata = sd_go ? sd_best : val_r;
      end
      S_PPR2: begin
        mem_we = 1'b1; mem_waddr = {p_sel, i_r[AB-1:0]};
        mem_wdata = sd_go ? sd_best : val_r;
      end
      S_PUR: if (i_r == '0) begin
        mem_we = 1'b1; mem_waddr = {u_sel, {AB{1'b0}}};
      end else begin
        mem_re = 1'b1; mem_raddr = {u_sel, c_par[AB-1:0]};
      end
      S_PUC: begin
        mem_we = 1'b1; mem_waddr = {u_sel, i_r[AB-1:0]};
        mem_wdata = pu_go ? rdata_r : val_r;
      end
      S_NEXT: begin
        mem_re = axis_r && !count_r[0]; mem_raddr = {H_XLO, {AB{1'b0}}};
      end
      S_MRX: begin
        mem_re = 1'b1; mem_raddr = {H_YLO, {AB{1'b0}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; o_mx_r <= '0; o_my_r <= '0; o_tot_r <= '0; o_drop_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1; o_mx_r <= med_x_r; o_my_r <= med_y_r;
      o_tot_r <= total_r; o_drop_r <= drop_r;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.median_x = o_mx_r;
  assign out_ch.median_y = o_my_r;
  assign out_ch.total_distance = o_tot_r;
  assign out_ch.dropped = o_drop_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rmd_pkg::count_t'(rmd_pkg::MaxPoints))
    else $error("point count exceeds capacity");
  a_ovhold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");
  a_ovstable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.total_distance) &&
    $stable(out_ch.median_x) && $stable(out_ch.median_y))
    else $error("result changed while stalled");
  a_oneitem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> pend_r)
    else $error("sequencer running without a point");
endmodule
`default_nettype wire

[tb/running_median_2d_distance_tb_if.sv]
// testbench-side notes: the channel interfaces come from hdl/rmd_if.sv
// this file holds the item and result structs shared by the testbench
// depends on rmd_pkg
`timescale 1ns / 100ps
package rmd_tb_pkg;
  typedef struct packed {
    logic            new_case;
    rmd_pkg::coord_t x_coord;
    rmd_pkg::coord_t y_coord;
  } point_t;

  typedef struct packed {
    rmd_pkg::coord_t median_x;
    rmd_pkg::coord_t median_y;
    rmd_pkg::total_t total_distance;
    logic            dropped;
  } median_result_t;
endpackage

[tb/running_median_2d_distance_top_tb.sv]
// testbench for running_median_2d_distance_top: bursty point driver, stalling
// result monitor, and a sorted-list median predictor checked per beat
// depends on rmd_pkg, rmd_if and rmd_tb_pkg
`timescale 1ns / 100ps
module running_median_2d_distance_top_tb;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 300;

  logic clk;
  logic rst_n;

  rmd_in_if  in_ch ();
  rmd_out_if out_ch ();

  running_median_2d_distance_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  rmd_tb_pkg::point_t         pending_points[$];
  rmd_tb_pkg::median_result_t expected_results[$];
  int             error_count;
  int             idle_cycles;
  bit             hold_off_req;

  // predictor state: sorted values hold the same multiset as the heaps
  longint xs_sorted[$];
  longint ys_sorted[$];
  rmd_pkg::coord_t held_x, held_y;
  rmd_pkg::total_t total_sum;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic sorted_insert(ref longint vals[$], input longint v);
    int pos;
    pos = 0;
    while (pos < vals.size() && vals[pos] < v) pos++;
    vals.insert(pos, v);
  endtask

  function automatic longint abs_diff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic predict_point(input rmd_tb_pkg::point_t p);
    rmd_tb_pkg::median_result_t r;
    longint d;
    longint room;
    if (p.new_case) begin
      xs_sorted.delete();
      ys_sorted.delete();
      held_x = '0;
      held_y = '0;
      total_sum = '0;
    end
    r.dropped = 1'b0;
    if (xs_sorted.size() >= rmd_pkg::MaxPoints) begin
      r.dropped = 1'b1;
    end else begin
      sorted_insert(xs_sorted, longint'(p.x_coord));
      sorted_insert(ys_sorted, longint'(p.y_coord));
      // lower median is element (n-1)/2 of the sorted list
      if (xs_sorted.size() % 2 == 1) begin
        held_x = rmd_pkg::coord_t'(xs_sorted[(xs_sorted.size() - 1) / 2]);
        held_y = rmd_pkg::coord_t'(ys_sorted[(ys_sorted.size() - 1) / 2]);
      end
      d = abs_diff(longint'(held_x), longint'(p.x_coord)) +
          abs_diff(longint'(held_y), longint'(p.y_coord));
      room = longint'(rmd_pkg::TotalMax) - longint'(total_sum);
      if (d >= room) total_sum = rmd_pkg::TotalMax;
      else total_sum = total_sum + rmd_pkg::total_t'(d);
    end
    r.median_x = held_x;
    r.median_y = held_y;
    r.total_distance = total_sum;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic rmd_pkg::coord_t rand_coord(int mode);
    case (mode)
      0: return rmd_pkg::coord_t'($urandom);
      1: return rmd_pkg::coord_t'($urandom_range(0, 40)) - 20;
      2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return rmd_pkg::coord_t'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic queue_point(input logic nc, input rmd_pkg::coord_t x,
                             input rmd_pkg::coord_t y);
    rmd_tb_pkg::point_t p;
    p.new_case = nc;
    p.x_coord = x;
    p.y_coord = y;
    pending_points.push_back(p);
  endtask

  // sender: bursts and gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.new_case <= 1'b0;
      in_ch.x_coord <= '0;
      in_ch.y_coord <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      automatic bit beat_done = in_ch.valid && in_ch.ready;
      automatic bit busy = in_ch.valid && !beat_done;
      if (beat_done) begin
        predict_point({in_ch.new_case, in_ch.x_coord, in_ch.y_coord});
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          automatic rmd_tb_pkg::point_t p = pending_points.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.new_case <= p.new_case;
          in_ch.x_coord <= p.x_coord;
          in_ch.y_coord <= p.y_coord;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus a long hold-off on request
  int stall_phase;
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase <= 0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", 64'd1, 64'd0);
        end else begin
          automatic rmd_tb_pkg::median_result_t e = expected_results.pop_front();
          if (out_ch.median_x !== e.median_x)
            report_mismatch("median_x", 64'(out_ch.median_x), 64'(e.median_x));
          if (out_ch.median_y !== e.median_y)
            report_mismatch("median_y", 64'(out_ch.median_y), 64'(e.median_y));
          if (out_ch.total_distance !== e.total_distance)
            report_mismatch("total_distance", 64'(out_ch.total_distance),
                            64'(e.total_distance));
          if (out_ch.dropped !== e.dropped)
            report_mismatch("dropped", 64'(out_ch.dropped), 64'(e.dropped));
        end
      end
      stall_phase <= stall_phase + 1;
      if (hold_off_req && hold_left == 0) begin
        hold_left <= 3000;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= (hold_left == 1);
      end else if (stall_phase[9:8] == 2'b00) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ((stall_phase % 7) < 4) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired at %0t", $realtime);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int mode;
    error_count = 0;
    hold_off_req = 0;
    held_x = '0;
    held_y = '0;
    total_sum = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: points with no new_case after reset, extremes, ties
    queue_point(1'b0, 32'sd5, -32'sd3);
    queue_point(1'b0, 32'sd1, 32'sd1);
    queue_point(1'b0, 32'sd5, 32'sd1);
    queue_point(1'b0, 32'sd5, 32'sd1);
    queue_point(1'b1, 32'sh7fffffff, 32'sh80000000);
    queue_point(1'b0, 32'sh80000000, 32'sh7fffffff);
    queue_point(1'b0, 32'sh80000000, 32'sh7fffffff);
    queue_point(1'b0, 32'sh7fffffff, 32'sh80000000);
    queue_point(1'b1, 32'sh00000000, 32'shffffffff);
    queue_point(1'b0, 32'shffffffff, 32'sh00000000);
    queue_point(1'b0, 32'sh55555555, 32'shaaaaaaaa);
    queue_point(1'b0, 32'shaaaaaaaa, 32'sh55555555);
    // extreme points far from the medians push the total up
    queue_point(1'b1, 32'sh80000000, 32'sh80000000);
    for (int i = 0; i < 8; i++)
      queue_point(1'b0, (i % 2) ? 32'sh80000000 : 32'sh7fffffff,
                  (i % 2) ? 32'sh80000000 : 32'sh7fffffff);

    // random cases of mostly small sets
    n = 0;
    while (n < 1150) begin
      automatic int len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 20);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        queue_point(i == 0 ? 1'b1 : ($urandom_range(0, 50) == 0),
                    rand_coord(mode), rand_coord($urandom_range(0, 3)));
        n++;
      end
      if (n > 600 && !hold_off_req) hold_off_req = 1;
    end

    wait (pending_points.size() == 0 && !(in_ch.valid));
    wait (expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // the hold-off request is consumed once
  always @(posedge clk) begin
    if (hold_left > 0) hold_off_req <= 1'b0;
  end
endmodule
